// ===== sv/tms_pkg.sv =====
// Shared types and constants for the totient / Mobius sieve table.
// No dependencies.
`timescale 1ns / 1ps
package tms_pkg;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [11:0] totient;
    logic [1:0]  mobius;
    logic        prime_flag;
    logic [11:0] least_factor;
  } tms_entry_t;

  typedef struct packed {
    logic        start;
    logic [11:0] divisor;
    logic [11:0] dividend;
  } tms_div_req_t;
endpackage

// ===== sv/tms_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tms_pkg.
`timescale 1ns / 1ps
module tms_div import tms_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tms_div_req_t req,
  output logic         done,
  output logic [11:0]  quot
);
  logic [11:0] rem;
  logic [11:0] q;
  logic [11:0] d;
  logic [3:0]  cnt;
  logic        busy;
  logic [12:0] trial;

  assign trial = {rem, q[11]} - {1'b0, d};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= '0;
        q <= req.dividend;
        d <= req.divisor;
        cnt <= 4'd0;
      end else if (busy) begin
        if (!trial[12]) begin
          rem <= trial[11:0];
          q <= {q[10:0], 1'b1};
        end else begin
          rem <= {rem[10:0], q[11]};
          q <= {q[10:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd11) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/totient_mobius_sieve_table.sv =====
// A query result turns valid after one table read and one output register, and
// a new query is accepted only once that result is registered. A build runs an
// init sweep over indices 0..limit, then tests each p in 2..limit, and for each
// prime p walks its multiples (read, divider start, wait on the divider with
// write-back when it finishes). Either result waits while the previous beat is
// still held on the output. Depends on tms_pkg and tms_div.
`timescale 1ns / 1ps
module totient_mobius_sieve_table import tms_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // index[11:0]
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // status, totient, mobius, prime_flag, least_factor
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [11:0] TOP = (TABLE_DEPTH > 4096) ? 12'hFFF : 12'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    IDLE, QREAD, QOUT, INIT, PSCAN, PREAD, KREAD, KDIV, KWAIT, OUT
  } state_t;

  state_t state;
  logic [11:0] limit, built_limit, top;
  logic tables_valid;
  logic [11:0] p, k, qidx;
  logic [11:0] kq;
  tms_entry_t mem [TABLE_DEPTH];
  tms_entry_t rd;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  tms_entry_t  wd;
  tms_entry_t  cur;
  tms_div_req_t dreq;
  logic ddone;
  logic [11:0] dq;
  logic [31:0] obuf;

  tms_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dq));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wd;
    rd <= mem[raddr];
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tdata = obuf;

  always_comb begin
    raddr = AW'(k);
    if (state == IDLE) raddr = AW'(s_axis_tdata[11:0]);
    else if (state == QREAD || state == QOUT) raddr = AW'(qidx);
    else if (state == PSCAN) raddr = AW'(p);
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(k);
    wd = '0;
    dreq = '{start: 1'b0, divisor: p, dividend: rd.totient};
    if (state == INIT) begin
      we = 1'b1;
      wd = '{totient: k, mobius: 2'b01, prime_flag: 1'b0, least_factor: 12'd0};
    end else if (state == KDIV) begin
      dreq.start = 1'b1;
    end else if (state == KWAIT && ddone) begin
      we = 1'b1;
      wd = cur;
      wd.totient = cur.totient - dq;
      if (cur.least_factor == 12'd0) wd.least_factor = p;
      if (k == p) wd.prime_flag = 1'b1;
      wd.mobius = (kq == 12'd0) ? 2'b00 : -cur.mobius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      limit <= 12'd4095;
      built_limit <= '0;
      tables_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        IDLE: if (s_axis_tvalid) begin
          qidx <= s_axis_tdata[11:0];
          if (s_axis_tuser == FUNC_BUILD) begin
            top <= (limit > TOP) ? TOP : limit;
            k <= '0;
            state <= INIT;
          end else begin
            state <= QREAD;
          end
        end
        QREAD: state <= QOUT;
        QOUT: if (!m_axis_tvalid) begin
          m_axis_tvalid <= 1'b1;
          if (!tables_valid) obuf <= {3'd0, 27'd0, ST_EMPTY};
          else if (qidx > built_limit) obuf <= {3'd0, 27'd0, ST_RANGE};
          else obuf <= {3'd0, rd.least_factor, rd.prime_flag, rd.mobius,
                         rd.totient, ST_OK};
          state <= IDLE;
        end
        INIT: begin
          k <= k + 12'd1;
          if (k == top) begin
            p <= 12'd2;
            state <= (top < 12'd2) ? OUT : PSCAN;
          end
        end
        PSCAN: state <= PREAD;
        PREAD: begin
          if (rd.totient == p) begin
            k <= p;
            kq <= 12'd1;
            state <= KREAD;
          end else if (p == top) state <= OUT;
          else begin
            p <= p + 12'd1;
            state <= PSCAN;
          end
        end
        KREAD: state <= KDIV;
        KDIV: begin
          cur <= rd;
          state <= KWAIT;
        end
        KWAIT: if (ddone) begin
          // kq tracks (k/p) mod p; zero means p*p | k
          if (kq + 12'd1 == p) kq <= 12'd0;
          else kq <= kq + 12'd1;
          if ({1'b0, k} + {1'b0, p} > {1'b0, top}) begin
            if (p == top) state <= OUT;
            else begin
              p <= p + 12'd1;
              state <= PSCAN;
            end
          end else begin
            k <= k + p;
            state <= KREAD;
          end
        end
        OUT: if (!m_axis_tvalid) begin
          built_limit <= top;
          tables_valid <= 1'b1;
          m_axis_tvalid <= 1'b1;
          obuf <= {3'd0, 27'd0, ST_OK};
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == IDLE) else $error("ready outside idle");
  ap_valid_after_build: assert property (@(posedge clk) disable iff (rst)
    (state == OUT && !m_axis_tvalid) |=> tables_valid) else $error("build flag");
  ap_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == IDLE |-> !we) else $error("table write while idle");
endmodule

// ===== test/totient_mobius_sieve_table_test.sv =====
// Self-checking bench for totient_mobius_sieve_table: builds and queries the
// sieve tables over many limits and compares every result with a local sieve.
// Depends on tms_pkg and the block's RTL.
`timescale 1ns / 1ps
module totient_mobius_sieve_table_test import tms_pkg::*;;

  localparam int DEPTH = 4096;
  localparam int CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic [1:0]  status;
    tms_entry_t  entry;
  } sieve_answer_t;

  class sieve_board;
    logic [11:0] tot_tab[DEPTH];
    logic [1:0]  mob_tab[DEPTH];
    logic        prime_tab[DEPTH];
    logic [11:0] lpf_tab[DEPTH];
    int unsigned built_top;
    bit          built;
    logic [11:0] limit_reg;
    sieve_answer_t answers[$];
    int errors;

    function void reset_state();
      built_top = 0;
      built = 0;
      limit_reg = 12'd4095;
      errors = 0;
      answers.delete();
    endfunction

    function void run_sieve();
      int unsigned top;
      int unsigned p;
      int unsigned k;
      int t[DEPTH];
      int m[DEPTH];
      top = (limit_reg > DEPTH - 1) ? DEPTH - 1 : limit_reg;
      for (int i = 0; i <= top; i++) begin
        t[i] = i;
        m[i] = 1;
        prime_tab[i] = 1'b0;
        lpf_tab[i] = '0;
      end
      for (p = 2; p <= top; p++) begin
        if (t[p] != p) continue;
        prime_tab[p] = 1'b1;
        for (k = p; k <= top; k += p) begin
          if (lpf_tab[k] == 0) lpf_tab[k] = p[11:0];
          t[k] = t[k] - t[k] / p;
          if ((k / p) % p == 0) m[k] = 0;
          else m[k] = -m[k];
        end
      end
      for (int i = 0; i <= top; i++) begin
        tot_tab[i] = t[i][11:0];
        mob_tab[i] = m[i][1:0];
      end
      built_top = top;
      built = 1;
    endfunction

    function void note_beat(logic func, logic [11:0] idx);
      sieve_answer_t a;
      a = '0;
      if (func == FUNC_BUILD) begin
        run_sieve();
        a.status = ST_OK;
      end else if (!built) begin
        a.status = ST_EMPTY;
      end else if (idx > built_top) begin
        a.status = ST_RANGE;
      end else begin
        a.status = ST_OK;
        a.entry.totient = tot_tab[idx];
        a.entry.mobius = mob_tab[idx];
        a.entry.prime_flag = prime_tab[idx];
        a.entry.least_factor = lpf_tab[idx];
      end
      answers.push_back(a);
    endfunction

    function void check_beat(logic [31:0] d);
      sieve_answer_t a;
      if (answers.size() == 0) begin
        $error("unexpected result beat %h", d);
        errors++;
        return;
      end
      a = answers.pop_front();
      if (d[1:0] !== a.status) begin
        $error("status expected %0d got %0d", a.status, d[1:0]);
        errors++;
      end
      if (d[13:2] !== a.entry.totient) begin
        $error("totient expected %0d got %0d", a.entry.totient, d[13:2]);
        errors++;
      end
      if (d[15:14] !== a.entry.mobius) begin
        $error("mobius expected %0d got %0d", a.entry.mobius, d[15:14]);
        errors++;
      end
      if (d[16] !== a.entry.prime_flag) begin
        $error("prime_flag expected %0d got %0d", a.entry.prime_flag, d[16]);
        errors++;
      end
      if (d[28:17] !== a.entry.least_factor) begin
        $error("least_factor expected %0d got %0d", a.entry.least_factor, d[28:17]);
        errors++;
      end
    endfunction

    function int pending();
      return answers.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // index[11:0]
  logic        s_axis_tuser = 1'b0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // status, totient, mobius, prime_flag, least_factor
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;

  sieve_board board = new();
  bit quiet;
  int unsigned cycles;
  int stall_left;

  totient_mobius_sieve_table i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("totient_mobius_sieve_table verification failed");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // result side: check, then decide next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic send(logic func, logic [11:0] idx);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {4'd0, idx};
    do @(posedge clk); while (!s_axis_tready);
    board.note_beat(func, idx);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [11:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    board.limit_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic query_phase(int n);
    int r;
    logic [11:0] idx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (r < 1 && board.limit_reg < 1200) begin
        send(FUNC_BUILD, 12'($urandom));
        continue;
      end
      if (r < 86) idx = 12'($urandom_range(0, board.built_top));
      else if (r < 95 && board.built_top < DEPTH - 1)
        idx = 12'($urandom_range(board.built_top + 1, DEPTH - 1));
      else idx = 12'($urandom);
      send(FUNC_QUERY, idx);
    end
    quiet = 0;
  endtask

  initial begin
    int lim;
    int r;
    board.reset_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(FUNC_QUERY, 12'd0);
    send(FUNC_QUERY, 12'd4095);
    send(FUNC_BUILD, 12'd0);
    send(FUNC_QUERY, 12'd0);
    send(FUNC_QUERY, 12'd1);
    send(FUNC_QUERY, 12'd2);
    send(FUNC_QUERY, 12'd4);
    send(FUNC_QUERY, 12'd30);
    send(FUNC_QUERY, 12'd97);
    send(FUNC_QUERY, 12'd210);
    send(FUNC_QUERY, 12'd2048);
    send(FUNC_QUERY, 12'd4093);
    send(FUNC_QUERY, 12'd4095);
    // pause until everything is back
    drain();
    send(FUNC_QUERY, 12'd3);
    set_limit(12'd0);
    send(FUNC_BUILD, 12'hfff);
    send(FUNC_QUERY, 12'd0);
    send(FUNC_QUERY, 12'd1);
    send(FUNC_QUERY, 12'd4095);
    set_limit(12'd1);
    send(FUNC_BUILD, 12'd0);
    send(FUNC_QUERY, 12'd1);
    send(FUNC_QUERY, 12'd2);

    for (int ph = 0; ph < 9; ph++) begin
      r = $urandom_range(0, 99);
      if (r < 70) lim = $urandom_range(2, 200);
      else if (r < 90) lim = $urandom_range(201, 1000);
      else lim = $urandom_range(1001, 2000);
      set_limit(lim[11:0]);
      send(FUNC_BUILD, 12'($urandom));
      query_phase(200);
    end
    set_limit(12'd4095);
    send(FUNC_BUILD, 12'($urandom));
    query_phase(150);

    drain();
    if (board.errors == 0) begin
      $display("totient_mobius_sieve_table verification clean");
    end else begin
      $display("totient_mobius_sieve_table verification failed");
    end
    $finish;
  end
endmodule
